FILE: hdl/atf_pkg.sv
package atf_pkg;

  // Character codes recognised by the line parser.
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Parser phase within an AT line.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_AT   = 4'b0010,
    PH_CMD  = 4'b0100,
    PH_CR   = 4'b1000
  } phase_t;

  // Controller sequencing: receive, read out a line, send the summary.
  typedef enum logic [3:0] {
    ST_RX   = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_SUM  = 4'b1000
  } ctrl_state_t;

  // One result word as it travels from the controller to the output register.
  typedef struct packed {
    logic       is_summary;
    logic [7:0] cmd_byte;
    logic [2:0] cmd_slot;
    logic       last_of_command;
    logic       buffer_valid;
    logic [3:0] command_count;
    logic       commands_dropped;
  } item_t;

endpackage

FILE: hdl/atf_line_ram.sv
module atf_line_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Single write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/atf_ctrl.sv
module atf_ctrl #(
  parameter int MAX_CMD_LEN  = 32,
  parameter int MAX_COMMANDS = 8,
  parameter int AW           = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                last_in_buffer,
  input  logic                out_free,
  output logic                item_load,
  output atf_pkg::item_t      item,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic [AW-1:0]       ram_raddr,
  input  logic [7:0]          ram_rdata
);

  localparam int FW = $clog2(MAX_CMD_LEN + 1);
  localparam int CW = $clog2(MAX_COMMANDS + 1);
  localparam logic [FW-1:0] LEN_LIMIT = FW'(MAX_CMD_LEN);
  localparam logic [CW-1:0] CMD_LIMIT = CW'(MAX_COMMANDS);

  atf_pkg::ctrl_state_t state, state_next;
  atf_pkg::phase_t      phase, phase_next, phase_eff;
  logic [FW-1:0]        fill, fill_next, fill_eff;
  logic [CW-1:0]        framed, framed_next;
  logic                 any_valid, any_valid_next;
  logic                 drop_flag, drop_flag_next;
  logic [AW-1:0]        rd_idx, rd_idx_next;
  logic [AW-1:0]        rd_last, rd_last_next;
  logic [2:0]           slot, slot_next;
  logic                 pending_sum, pending_sum_next;
  logic                 start_rd;
  logic                 fill_full;

  // Low three bits of a slot number.
  function automatic logic [2:0] slot_bits(input logic [CW-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[2:0];
  endfunction

  // Builds the end-of-buffer summary word.
  function automatic atf_pkg::item_t summary_item(input logic any, input logic [CW-1:0] cnt,
                                                  input logic dropped);
    atf_pkg::item_t it;
    logic [31:0]    wide;
    wide = 32'(cnt);
    it = '0;
    it.is_summary       = 1'b1;
    it.buffer_valid     = any;
    it.command_count    = wide[3:0];
    it.commands_dropped = dropped;
    return it;
  endfunction

  assign in_ready  = (state == atf_pkg::ST_RX) && out_free;
  assign ram_raddr = rd_idx;
  assign ram_wdata = rx_byte;

  // A byte other than LF after CR abandons the line and is taken as in idle.
  always_comb begin
    if (phase == atf_pkg::PH_CR && rx_byte != atf_pkg::CH_LF) begin
      phase_eff = atf_pkg::PH_IDLE;
      fill_eff  = '0;
    end else begin
      phase_eff = phase;
      fill_eff  = fill;
    end
  end

  assign fill_full = (fill_eff >= LEN_LIMIT);
  assign ram_waddr = fill_eff[AW-1:0];

  // Parser, line read-out and summary sequencing.
  always_comb begin
    state_next       = state;
    phase_next       = phase;
    fill_next        = fill;
    framed_next      = framed;
    any_valid_next   = any_valid;
    drop_flag_next   = drop_flag;
    rd_idx_next      = rd_idx;
    rd_last_next     = rd_last;
    slot_next        = slot;
    pending_sum_next = pending_sum;
    start_rd         = 1'b0;
    ram_we           = 1'b0;
    item_load        = 1'b0;
    item             = '0;

    unique case (state)
      atf_pkg::ST_RX: begin
        if (in_valid && in_ready) begin
          phase_next = phase_eff;
          fill_next  = fill_eff;
          unique case (phase_eff)
            atf_pkg::PH_IDLE: begin
              if (rx_byte == atf_pkg::CH_A) begin
                ram_we     = 1'b1;
                fill_next  = FW'(1);
                phase_next = atf_pkg::PH_AT;
              end
            end
            atf_pkg::PH_AT: begin
              if (rx_byte == atf_pkg::CH_T) begin
                ram_we     = 1'b1;
                fill_next  = fill_eff + FW'(1);
                phase_next = atf_pkg::PH_CMD;
              end else if (rx_byte != atf_pkg::CH_A) begin
                fill_next  = '0;
                phase_next = atf_pkg::PH_IDLE;
              end
            end
            atf_pkg::PH_CMD: begin
              if (fill_full) begin
                drop_flag_next = 1'b1;
                fill_next      = '0;
                phase_next     = atf_pkg::PH_IDLE;
              end else begin
                ram_we    = 1'b1;
                fill_next = fill_eff + FW'(1);
                if (rx_byte == atf_pkg::CH_CR) begin
                  phase_next = atf_pkg::PH_CR;
                end
              end
            end
            atf_pkg::PH_CR: begin
              // Here the byte is LF: store it unless the line is full, and hand the line out if a slot is free.
              fill_next  = '0;
              phase_next = atf_pkg::PH_IDLE;
              if (fill_full) begin
                drop_flag_next = 1'b1;
              end else begin
                ram_we = 1'b1;
                if (framed >= CMD_LIMIT) begin
                  drop_flag_next = 1'b1;
                end else begin
                  start_rd       = 1'b1;
                  framed_next    = framed + CW'(1);
                  any_valid_next = 1'b1;
                end
              end
            end
            default: begin
              phase_next = atf_pkg::PH_IDLE;
            end
          endcase

          if (start_rd) begin
            state_next       = atf_pkg::ST_READ;
            rd_idx_next      = '0;
            rd_last_next     = fill_eff[AW-1:0];
            slot_next        = slot_bits(framed);
            pending_sum_next = last_in_buffer;
          end else if (last_in_buffer) begin
            item_load      = 1'b1;
            item           = summary_item(any_valid_next, framed_next, drop_flag_next);
            phase_next     = atf_pkg::PH_IDLE;
            fill_next      = '0;
            framed_next    = '0;
            any_valid_next = 1'b0;
            drop_flag_next = 1'b0;
          end
        end
      end
      atf_pkg::ST_READ: begin
        state_next = atf_pkg::ST_LOAD;
      end
      atf_pkg::ST_LOAD: begin
        if (out_free) begin
          item_load            = 1'b1;
          item.cmd_byte        = ram_rdata;
          item.cmd_slot        = slot;
          item.last_of_command = (rd_idx == rd_last);
          if (rd_idx == rd_last) begin
            state_next = pending_sum ? atf_pkg::ST_SUM : atf_pkg::ST_RX;
          end else begin
            rd_idx_next = rd_idx + AW'(1);
            state_next  = atf_pkg::ST_READ;
          end
        end
      end
      atf_pkg::ST_SUM: begin
        if (out_free) begin
          item_load        = 1'b1;
          item             = summary_item(any_valid, framed, drop_flag);
          framed_next      = '0;
          any_valid_next   = 1'b0;
          drop_flag_next   = 1'b0;
          pending_sum_next = 1'b0;
          state_next       = atf_pkg::ST_RX;
        end
      end
      default: begin
        state_next = atf_pkg::ST_RX;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= atf_pkg::ST_RX;
      phase       <= atf_pkg::PH_IDLE;
      fill        <= '0;
      framed      <= '0;
      any_valid   <= 1'b0;
      drop_flag   <= 1'b0;
      pending_sum <= 1'b0;
      rd_idx      <= '0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      fill        <= fill_next;
      framed      <= framed_next;
      any_valid   <= any_valid_next;
      drop_flag   <= drop_flag_next;
      pending_sum <= pending_sum_next;
      rd_idx      <= rd_idx_next;
    end
  end

  // Read-out bookkeeping needs no reset.
  always_ff @(posedge clk) begin
    rd_last <= rd_last_next;
    slot    <= slot_next;
  end

endmodule

FILE: hdl/at_command_line_framer.sv
// Channel  Direction  Handshake             Word
// input    in         in_valid / in_ready   rx_byte, last_in_buffer
// output   out        out_valid / out_ready is_summary, cmd_byte, cmd_slot, last_of_command,
//                                           buffer_valid, command_count, commands_dropped
//
// A byte that completes no command does not pause the input; input flows one word per cycle
// while the output register is free. A completed line is read back from the line store
// byte by byte (memory read, then output load), so input pauses meanwhile and for a summary that follows it.
// The output register frees the input whenever its word is taken in the same cycle.
// Synchronous reset returns the parser to idle and empties the output register; the line
// store needs no clearing.
module at_command_line_framer #(
  parameter int MAX_CMD_LEN  = 32,
  parameter int MAX_COMMANDS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       last_in_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_summary,
  output logic [7:0] cmd_byte,
  output logic [2:0] cmd_slot,
  output logic       last_of_command,
  output logic       buffer_valid,
  output logic [3:0] command_count,
  output logic       commands_dropped
);

  localparam int AW = $clog2(MAX_CMD_LEN);

  logic           out_free;
  logic           item_load;
  atf_pkg::item_t item;
  atf_pkg::item_t out_word;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  assign out_free = !out_valid || out_ready;

  atf_ctrl #(
    .MAX_CMD_LEN  (MAX_CMD_LEN),
    .MAX_COMMANDS (MAX_COMMANDS),
    .AW           (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .last_in_buffer (last_in_buffer),
    .out_free       (out_free),
    .item_load      (item_load),
    .item           (item),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  atf_line_ram #(
    .DEPTH (MAX_CMD_LEN),
    .AW    (AW)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (item_load) begin
      out_word <= item;
    end
  end

  assign is_summary       = out_word.is_summary;
  assign cmd_byte         = out_word.cmd_byte;
  assign cmd_slot         = out_word.cmd_slot;
  assign last_of_command  = out_word.last_of_command;
  assign buffer_valid     = out_word.buffer_valid;
  assign command_count    = out_word.command_count;
  assign commands_dropped = out_word.commands_dropped;

endmodule

FILE: tb/sv/at_framer_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the AT line framer, predicts every result word
// from the accepted input words and compares them in order.
module at_framer_checker #(
  parameter int MAX_CMD_LEN  = 32,
  parameter int MAX_COMMANDS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       last_in_buffer,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       is_summary,
  input  logic [7:0] cmd_byte,
  input  logic [2:0] cmd_slot,
  input  logic       last_of_command,
  input  logic       buffer_valid,
  input  logic [3:0] command_count,
  input  logic       commands_dropped,
  output int         fail_count,
  output int         pending
);

  // Own copy of the parser state.
  atf_pkg::phase_t line_phase;
  logic [7:0]      line_buf [MAX_CMD_LEN];
  int              line_fill;
  int              lines_framed;
  bit              seen_command;
  bit              lost_command;

  atf_pkg::item_t  expected_words [$];
  atf_pkg::item_t  want;

  // Appends one byte to the line buffer; an overfull line is thrown away.
  function automatic bit keep_byte(input logic [7:0] b);
    if (line_fill >= MAX_CMD_LEN) begin
      lost_command = 1'b1;
      line_fill    = 0;
      line_phase   = atf_pkg::PH_IDLE;
      return 1'b0;
    end
    line_buf[line_fill] = b;
    line_fill++;
    return 1'b1;
  endfunction

  // Advances the parser by one received byte and queues the words it causes.
  function automatic void frame_byte(input logic [7:0] b, input logic last);
    atf_pkg::item_t w;
    // A CR must be followed by LF, otherwise the byte is looked at afresh.
    if (line_phase == atf_pkg::PH_CR && b != atf_pkg::CH_LF) begin
      line_fill  = 0;
      line_phase = atf_pkg::PH_IDLE;
    end
    case (line_phase)
      atf_pkg::PH_IDLE: begin
        if (b == atf_pkg::CH_A) begin
          line_fill = 0;
          if (keep_byte(b)) line_phase = atf_pkg::PH_AT;
        end
      end
      atf_pkg::PH_AT: begin
        if (b == atf_pkg::CH_T) begin
          if (keep_byte(b)) line_phase = atf_pkg::PH_CMD;
        end else if (b != atf_pkg::CH_A) begin
          line_fill  = 0;
          line_phase = atf_pkg::PH_IDLE;
        end
      end
      atf_pkg::PH_CMD: begin
        if (keep_byte(b) && b == atf_pkg::CH_CR) line_phase = atf_pkg::PH_CR;
      end
      default: begin
        if (keep_byte(b)) begin
          if (lines_framed >= MAX_COMMANDS) begin
            lost_command = 1'b1;
          end else begin
            for (int i = 0; i < line_fill; i++) begin
              w                 = '0;
              w.cmd_byte        = line_buf[i];
              w.cmd_slot        = lines_framed[2:0];
              w.last_of_command = (i == line_fill - 1);
              expected_words.push_back(w);
            end
            lines_framed++;
            seen_command = 1'b1;
          end
          line_fill  = 0;
          line_phase = atf_pkg::PH_IDLE;
        end
      end
    endcase
    // The end of a receive buffer reports and then clears the parser.
    if (last) begin
      w                  = '0;
      w.is_summary       = 1'b1;
      w.buffer_valid     = seen_command;
      w.command_count    = lines_framed[3:0];
      w.commands_dropped = lost_command;
      expected_words.push_back(w);
      line_phase   = atf_pkg::PH_IDLE;
      line_fill    = 0;
      lines_framed = 0;
      seen_command = 1'b0;
      lost_command = 1'b0;
    end
  endfunction

  function automatic void check_field(input string field, input int exp_val,
                                      input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val,
               act_val);
      fail_count++;
    end
  endfunction

  // Compare each word taken from the block, then predict from the word taken in.
  always @(posedge clk) begin
    if (rst) begin
      line_phase   = atf_pkg::PH_IDLE;
      line_fill    = 0;
      lines_framed = 0;
      seen_command = 1'b0;
      lost_command = 1'b0;
      fail_count   = 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual summary %0b byte %0h",
                   $time, is_summary, cmd_byte);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("is_summary", want.is_summary, is_summary);
          check_field("cmd_byte", want.cmd_byte, cmd_byte);
          check_field("cmd_slot", want.cmd_slot, cmd_slot);
          check_field("last_of_command", want.last_of_command, last_of_command);
          check_field("buffer_valid", want.buffer_valid, buffer_valid);
          check_field("command_count", want.command_count, command_count);
          check_field("commands_dropped", want.commands_dropped, commands_dropped);
        end
      end
      if (in_valid && in_ready) frame_byte(rx_byte, last_in_buffer);
    end
    pending = expected_words.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Drives byte streams into the AT line framer and gives the verdict.
module tb_top;

  localparam int LINE_LEN    = 32;
  localparam int SLOT_COUNT  = 8;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_WORDS = 45;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       last_in_buffer = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       is_summary;
  logic [7:0] cmd_byte;
  logic [2:0] cmd_slot;
  logic       last_of_command;
  logic       buffer_valid;
  logic [3:0] command_count;
  logic       commands_dropped;

  int         fail_count;
  int         pending;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;
  logic [7:0] rx_stream [$];

  always #2 clk = ~clk;

  at_command_line_framer #(
    .MAX_CMD_LEN (LINE_LEN),
    .MAX_COMMANDS(SLOT_COUNT)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .last_in_buffer  (last_in_buffer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .is_summary      (is_summary),
    .cmd_byte        (cmd_byte),
    .cmd_slot        (cmd_slot),
    .last_of_command (last_of_command),
    .buffer_valid    (buffer_valid),
    .command_count   (command_count),
    .commands_dropped(commands_dropped)
  );

  at_framer_checker #(
    .MAX_CMD_LEN (LINE_LEN),
    .MAX_COMMANDS(SLOT_COUNT)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .last_in_buffer  (last_in_buffer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .is_summary      (is_summary),
    .cmd_byte        (cmd_byte),
    .cmd_slot        (cmd_slot),
    .last_of_command (last_of_command),
    .buffer_valid    (buffer_valid),
    .command_count   (command_count),
    .commands_dropped(commands_dropped),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Give up once neither channel has moved a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one word, with random gaps before it, and waits until it is taken.
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    rx_byte        <= b;
    last_in_buffer <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sends the prepared stream as one receive buffer, optionally with stray ends.
  task automatic push_buffer(input bit stray_last);
    foreach (rx_stream[i]) begin
      send_word(rx_stream[i],
                (i == rx_stream.size() - 1) || (stray_last && $urandom_range(63) == 0));
    end
  endtask

  task automatic add_chars(input string s);
    for (int i = 0; i < s.len(); i++) rx_stream.push_back(s[i]);
  endtask

  // A well-formed line, sometimes with repeated A before the T.
  task automatic add_line(input int body_len);
    rx_stream.push_back(atf_pkg::CH_A);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) rx_stream.push_back(atf_pkg::CH_A);
    end
    rx_stream.push_back(atf_pkg::CH_T);
    repeat (body_len) rx_stream.push_back(8'($urandom_range(255)));
    rx_stream.push_back(atf_pkg::CH_CR);
    rx_stream.push_back(atf_pkg::CH_LF);
  endtask

  // Mostly good lines with random content; the rest is noise and broken lines.
  task automatic build_buffer();
    rx_stream.delete();
    if ($urandom_range(3) == 0) begin
      // Enough lines to fill every slot, at times more lines than there are slots.
      repeat ($urandom_range(SLOT_COUNT, SLOT_COUNT + 2)) add_line($urandom_range(0, 3));
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: add_line($urandom_range(0, 6));
          6: repeat ($urandom_range(1, 3)) rx_stream.push_back(8'($urandom_range(255)));
          7: begin
            rx_stream.push_back(atf_pkg::CH_A);
            rx_stream.push_back(8'($urandom_range(255)));
          end
          8: begin
            // CR followed by something other than LF, often a fresh A.
            rx_stream.push_back(atf_pkg::CH_A);
            rx_stream.push_back(atf_pkg::CH_T);
            repeat ($urandom_range(0, 3)) rx_stream.push_back(8'($urandom_range(255)));
            rx_stream.push_back(atf_pkg::CH_CR);
            rx_stream.push_back($urandom_range(1) ? atf_pkg::CH_A : 8'($urandom_range(255)));
          end
          default: add_line($urandom_range(LINE_LEN - 5, LINE_LEN - 2));
        endcase
      end
    end
  endtask

  // Holds the input back until every predicted word has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int gap_rate [4];
    int stall_rate [4];
    int phase_words;
    gap_rate   = '{0, 79, 0, 13};
    stall_rate = '{0, 0, 79, 13};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Repeated A, a broken start, CR without LF re-examined as A, extreme bytes.
    rx_stream.delete();
    add_chars("AAAT");
    rx_stream.push_back(atf_pkg::CH_CR);
    rx_stream.push_back(atf_pkg::CH_LF);
    rx_stream.push_back(atf_pkg::CH_A);
    rx_stream.push_back(8'hFF);
    add_chars("AT");
    rx_stream.push_back(atf_pkg::CH_CR);
    add_chars("AT");
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(atf_pkg::CH_CR);
    rx_stream.push_back(atf_pkg::CH_LF);
    push_buffer(1'b0);
    // A buffer holding one noise byte, then one whose end falls on the LF of a line.
    rx_stream.delete();
    rx_stream.push_back(8'h00);
    push_buffer(1'b0);
    rx_stream.delete();
    add_chars("AT");
    rx_stream.push_back(atf_pkg::CH_CR);
    rx_stream.push_back(atf_pkg::CH_LF);
    push_buffer(1'b0);
    drain_results();

    // Random buffers under each idling pattern.
    for (int p = 0; p < 4; p++) begin
      gap_pct     <= gap_rate[p];
      stall_pct   <= stall_rate[p];
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        build_buffer();
        phase_words += rx_stream.size();
        push_buffer(1'b1);
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/atf_pkg.sv
hdl/atf_line_ram.sv
hdl/atf_ctrl.sv
hdl/at_command_line_framer.sv
tb/sv/at_framer_checker.sv
tb/sv/tb_top.sv
